// ===== src/irf_pkg.sv =====
package irf_pkg;

  localparam int ADC_BITS = 10;

  typedef enum logic [1:0] {
    OP_IR_SAMPLE = 2'd0,
    OP_ECHO      = 2'd1,
    OP_FINISH    = 2'd2,
    OP_CALIBRATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MIN_RANGE = 2'd0,
    REG_MAX_RANGE = 2'd1,
    REG_US_COUNT  = 2'd2
  } reg_idx_t;

  localparam logic [2:0] CLASS_NONE      = 3'd0;
  localparam logic [2:0] CLASS_CLOSE     = 3'd1;
  localparam logic [2:0] CLASS_OUT_OF_IR = 3'd2;
  localparam logic [2:0] CLASS_GOOD      = 3'd3;
  localparam logic [2:0] CLASS_BAD_DIR   = 3'd4;

  localparam logic [31:0] IR_SCALE      = 32'd135174;
  localparam logic [31:0] IR_BIAS       = 32'd28;
  localparam logic [ADC_BITS-1:0] IR_MIN_ADC = ADC_BITS'(100);
  localparam logic [8:0]  US_SCALE      = 9'd285;
  localparam logic [12:0] US_BIAS       = 13'd18;
  localparam logic [15:0] US_MIN_ECHO   = 16'h0100;
  localparam logic [15:0] CLOSE_LOW     = 16'd150;
  localparam logic [15:0] CLOSE_HIGH    = 16'd450;
  localparam logic [15:0] FAR_LIMIT     = 16'd1000;
  localparam logic [15:0] US_ONLY_LIMIT = 16'd1500;

  typedef struct packed {
    logic [1:0]          op;
    logic [ADC_BITS-1:0] adc_value;
    logic [15:0]         echo_time;
    logic                echo_timeout;
    logic [15:0]         reference;
  } in_item_t;

  typedef struct packed {
    logic [15:0] fused_range;
    logic [2:0]  target_class;
    logic [15:0] raw_ir_range;
    logic [15:0] raw_us_range;
  } out_item_t;

endpackage

// ===== src/irf_div.sv =====
module irf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [15:0] rem;
  logic [15:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] diff;

  assign diff = {1'b0, rem, quotient[31]} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (diff[17]) begin
          rem      <= {rem[14:0], quotient[31]};
          quotient <= {quotient[30:0], 1'b0};
        end else begin
          rem      <= diff[15:0];
          quotient <= {quotient[30:0], 1'b1};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/ir_ultrasonic_range_fusion.sv =====
// A finish item runs two 32-step serial divisions (ultrasonic average, then IR
// average), window and offset, and classify; a division with a zero divisor is skipped.
// Throughput: one item at a time; in_stall holds the next transfer while a taken IR
// sample is divided or a finish is processed (echo and calibrate do not stall), plus any
// out_stall wait while a previous result is still held.
// Reset: synchronous; clears sums, offsets and class and restores the registers.
module ir_ultrasonic_range_fusion #(
  parameter int MAX_IR_SAMPLES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  irf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output irf_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [16:0] IR_LIMIT = 17'(MAX_IR_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_IR_WAIT,
    S_US_START,
    S_US_WAIT,
    S_AVG_START,
    S_AVG_WAIT,
    S_WIN,
    S_FUSE
  } state_t;

  state_t state;

  logic [15:0] min_range;
  logic [15:0] max_range;
  logic [7:0]  us_sample_count;
  logic [31:0] ir_sum;
  logic [15:0] ir_count;
  logic [31:0] us_sum;
  logic [15:0] last_ir_raw;
  logic [15:0] last_us_raw;
  logic [2:0]  last_class;
  logic [16:0] ir_offset;
  logic [16:0] us_offset;
  logic [31:0] us_avg;
  logic [31:0] ir_avg;
  logic [15:0] us_cal;
  logic [15:0] ir_cal;
  logic        us_ok;
  logic        ir_ok;

  logic        accept;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quotient;
  logic        ir_take;
  logic [24:0] echo_prod;
  logic [12:0] echo_t;
  logic [31:0] echo_d;
  logic        us_in_win;
  logic        ir_in_win;
  logic [16:0] cal_sum;
  logic [15:0] fused_next;
  logic [2:0]  class_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign ir_take = (in_data.adc_value > irf_pkg::IR_MIN_ADC) && ({1'b0, ir_count} < IR_LIMIT);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = irf_pkg::IR_SCALE;
    div_divisor  = 16'(in_data.adc_value);
    unique case (state)
      S_IDLE: begin
        div_start = accept && (in_data.op == irf_pkg::OP_IR_SAMPLE) && ir_take;
      end
      S_US_START: begin
        div_start    = (us_sample_count != 8'd0);
        div_dividend = us_sum;
        div_divisor  = 16'(us_sample_count);
      end
      S_AVG_START: begin
        div_start    = (ir_count != 16'd0);
        div_dividend = ir_sum;
        div_divisor  = ir_count;
      end
      default: begin
      end
    endcase
  end

  irf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign echo_prod = in_data.echo_time * irf_pkg::US_SCALE;
  assign echo_t    = echo_prod[24:12];
  always_comb begin
    echo_d = '0;
    if (!in_data.echo_timeout && (in_data.echo_time >= irf_pkg::US_MIN_ECHO) &&
        (echo_t >= irf_pkg::US_BIAS)) begin
      echo_d = 32'(echo_t - irf_pkg::US_BIAS);
    end
  end

  assign us_in_win = (us_avg <= 32'(max_range)) && (us_avg >= 32'(min_range)) &&
                     (us_avg != 32'd0);
  assign ir_in_win = (ir_avg <= 32'(max_range)) && (ir_avg >= 32'(min_range)) &&
                     (ir_avg != 32'd0);

  assign cal_sum = {1'b0, us_cal} + {1'b0, ir_cal};

  always_comb begin
    fused_next = '0;
    class_next = irf_pkg::CLASS_NONE;
    priority if (us_ok && ir_ok) begin
      priority if (us_cal >= irf_pkg::CLOSE_LOW && us_cal <= irf_pkg::CLOSE_HIGH) begin
        fused_next = ir_cal;
        class_next = irf_pkg::CLASS_CLOSE;
      end else if (us_cal >= irf_pkg::FAR_LIMIT && ir_cal >= irf_pkg::FAR_LIMIT) begin
        fused_next = us_cal;
        class_next = irf_pkg::CLASS_OUT_OF_IR;
      end else begin
        fused_next = {1'b0, cal_sum[15:1]};
        class_next = irf_pkg::CLASS_GOOD;
      end
    end else if (us_ok) begin
      fused_next = us_cal;
      class_next = (us_cal > irf_pkg::US_ONLY_LIMIT) ? irf_pkg::CLASS_OUT_OF_IR
                                                     : irf_pkg::CLASS_BAD_DIR;
    end else if (ir_ok) begin
      fused_next = ir_cal;
      class_next = irf_pkg::CLASS_CLOSE;
    end else begin
      fused_next = '0;
      class_next = irf_pkg::CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      min_range       <= 16'd300;
      max_range       <= 16'd1000;
      us_sample_count <= 8'd1;
      ir_sum          <= '0;
      ir_count        <= '0;
      us_sum          <= '0;
      last_ir_raw     <= '0;
      last_us_raw     <= '0;
      last_class      <= irf_pkg::CLASS_NONE;
      ir_offset       <= '0;
      us_offset       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FUSE) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          irf_pkg::REG_MIN_RANGE: min_range       <= cfg_data;
          irf_pkg::REG_MAX_RANGE: max_range       <= cfg_data;
          irf_pkg::REG_US_COUNT:  us_sample_count <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.op)
              irf_pkg::OP_IR_SAMPLE: begin
                if (ir_take) begin
                  state <= S_IR_WAIT;
                end
              end
              irf_pkg::OP_ECHO: begin
                us_sum <= us_sum + echo_d;
              end
              irf_pkg::OP_FINISH: begin
                state <= S_US_START;
              end
              irf_pkg::OP_CALIBRATE: begin
                if (last_class != irf_pkg::CLASS_NONE && last_class != irf_pkg::CLASS_CLOSE) begin
                  us_offset <= {1'b0, in_data.reference} - {1'b0, last_us_raw};
                end
                if (last_class == irf_pkg::CLASS_GOOD || last_class == irf_pkg::CLASS_CLOSE) begin
                  ir_offset <= {1'b0, in_data.reference} - {1'b0, last_ir_raw};
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_IR_WAIT: begin
          if (div_done) begin
            ir_sum   <= ir_sum + div_quotient - irf_pkg::IR_BIAS;
            ir_count <= ir_count + 16'd1;
            state    <= S_IDLE;
          end
        end
        S_US_START: begin
          us_avg <= '0;
          state  <= (us_sample_count != 8'd0) ? S_US_WAIT : S_AVG_START;
        end
        S_US_WAIT: begin
          if (div_done) begin
            us_avg <= div_quotient;
            state  <= S_AVG_START;
          end
        end
        S_AVG_START: begin
          ir_avg <= '0;
          state  <= (ir_count != 16'd0) ? S_AVG_WAIT : S_WIN;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            ir_avg <= div_quotient;
            state  <= S_WIN;
          end
        end
        S_WIN: begin
          last_us_raw <= us_avg[15:0];
          last_ir_raw <= ir_avg[15:0];
          us_ok       <= us_in_win;
          ir_ok       <= ir_in_win;
          us_cal      <= us_avg[15:0] + us_offset[15:0];
          ir_cal      <= ir_avg[15:0] + ir_offset[15:0];
          state       <= S_FUSE;
        end
        S_FUSE: begin
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_data.fused_range  <= fused_next;
            out_data.target_class <= class_next;
            out_data.raw_ir_range <= last_ir_raw;
            out_data.raw_us_range <= last_us_raw;
            last_class            <= class_next;
            ir_sum                <= '0;
            ir_count              <= '0;
            us_sum                <= '0;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
